### hdl/nested_chunk_envelope_checker_macros.svh
// Assertion macros shared by the nested chunk envelope checker modules.
`ifndef NESTED_CHUNK_ENVELOPE_CHECKER_MACROS_SVH
`define NESTED_CHUNK_ENVELOPE_CHECKER_MACROS_SVH

// Plain property, sampled on clk and held off while rst_n is low.
`define NCE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define NCE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/nce_pkg.sv
// Shared constants, codes and control types of the nested chunk envelope checker.
`timescale 1ns / 1ps

package nce_pkg;

    // Default sizing
    localparam int STACK_ENTRIES_DEF = 256;
    localparam int OFFSET_BITS_DEF   = 24;

    // Register port
    localparam int REG_W       = 24;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_LIMIT    = 1'b1;
    localparam logic [REG_W-1:0]       SIZE_LIMIT_RESET  = 24'hFF_FFFF;

    // Chunk header layout
    localparam int HEADER_BYTES   = 8;
    localparam int SIZE_FIRST_POS = 4;
    localparam int NESTED_BIT     = 31;

    // Verdict codes
    typedef logic [1:0] verdict_t;
    localparam verdict_t VERDICT_CHECKING  = 2'd0;
    localparam verdict_t VERDICT_ACCEPTED  = 2'd1;
    localparam verdict_t VERDICT_REJECTED  = 2'd2;
    localparam verdict_t VERDICT_CANCELLED = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic check;
        logic pop_load;
        logic out_load_next;
        logic out_load_cur;
    } nce_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_check;
        logic at_end;
        logic at_root;
    } nce_status_t;

endpackage

### hdl/nce_in_if.sv
// Input byte channel: valid/ready handshake with one buffer byte per item.
`timescale 1ns / 1ps

interface nce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       cancel;

    modport source (output valid, output data_byte, output first_byte, output cancel,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input cancel,
                  output ready);
endinterface

### hdl/nce_out_if.sv
// Result channel: valid/ready handshake with verdict and nesting level per item.
`timescale 1ns / 1ps

interface nce_out_if;
    logic                valid;
    logic                ready;
    nce_pkg::verdict_t   verdict;
    logic [7:0]          nesting_level;

    modport source (output valid, output verdict, output nesting_level, input ready);
    modport sink (input valid, input verdict, input nesting_level, output ready);
endinterface

### hdl/nce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module nce_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/nce_datapath.sv
// Datapath: config registers, header parsing, offset tracking and the end-offset stack.
`timescale 1ns / 1ps
`include "nested_chunk_envelope_checker_macros.svh"

module nce_datapath #(
    parameter int STACK_ENTRIES = nce_pkg::STACK_ENTRIES_DEF,
    parameter int OFFSET_BITS   = nce_pkg::OFFSET_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [nce_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  logic [nce_pkg::REG_W-1:0]            wr_data,
    input  logic [7:0]                           in_data_byte,
    input  logic                                 in_first_byte,
    input  logic                                 in_cancel,
    input  nce_pkg::nce_cmd_t                    cmd,
    output nce_pkg::nce_status_t                 status,
    output nce_pkg::verdict_t                    out_verdict,
    output logic [7:0]                           out_nesting_level
);

    localparam int OPEN_W   = $clog2(STACK_ENTRIES);
    localparam int MAX_OPEN = STACK_ENTRIES - 2;
    localparam logic [31:0] OFF_MAX = 32'((64'd1 << OFFSET_BITS) - 64'd1);
    localparam logic [2:0]  HDR_LAST  = 3'(nce_pkg::HEADER_BYTES - 1);
    localparam logic [2:0]  HDR_SIZE0 = 3'(nce_pkg::SIZE_FIRST_POS);

    // Config registers
    logic [nce_pkg::REG_W-1:0] buffer_length_reg;
    logic [nce_pkg::REG_W-1:0] size_limit_reg;

    // Captured item
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       cancel_reg;

    // Checker state
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [2:0]             hdr_pos_reg, hdr_pos_next;
    logic [31:0]            size_word_reg, size_word_next;
    logic [OFFSET_BITS-1:0] skip_reg, skip_next;
    logic [OPEN_W-1:0]      open_levels_reg, open_levels_next;
    logic [OFFSET_BITS-1:0] top_end_reg, top_end_next;
    nce_pkg::verdict_t      outcome_reg, outcome_next;

    // Result register
    nce_pkg::verdict_t      verdict_out_reg;
    logic [7:0]             level_out_reg;

    // Stack memory port
    logic                   mem_we;
    logic [OPEN_W-1:0]      mem_waddr;
    logic [OFFSET_BITS-1:0] mem_wdata;
    logic                   mem_re;
    logic [OPEN_W-1:0]      mem_raddr;
    logic [OFFSET_BITS-1:0] mem_rdata;

    // Byte step terms
    logic                   idle;
    logic                   start;
    logic [31:0]            blen32;
    logic                   bad_len;
    logic [OFFSET_BITS-1:0] s_off;
    logic [2:0]             s_hp;
    logic [31:0]            s_sw;
    logic [OFFSET_BITS-1:0] s_skip;
    logic [OPEN_W-1:0]      s_open;
    logic [OFFSET_BITS-1:0] s_top;
    nce_pkg::verdict_t      s_outcome;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [31:0]            sw_shift;
    logic [31:0]            payload32;
    logic [OFFSET_BITS-1:0] room;
    logic [OFFSET_BITS-1:0] new_end;
    logic [OFFSET_BITS-1:0] st_off;
    logic [2:0]             st_hp;
    logic [31:0]            st_sw;
    logic [OFFSET_BITS-1:0] st_skip;
    logic [OPEN_W-1:0]      st_open;
    logic [OFFSET_BITS-1:0] st_top;
    nce_pkg::verdict_t      st_outcome;
    logic                   st_push;

    // Boundary check terms
    logic                   at_end;
    logic                   at_root;
    logic [OFFSET_BITS-1:0] gap;
    logic                   short_gap;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= '0;
            size_limit_reg    <= nce_pkg::SIZE_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                nce_pkg::CFG_BUFFER_LENGTH: buffer_length_reg <= wr_data;
                nce_pkg::CFG_SIZE_LIMIT:    size_limit_reg    <= wr_data;
                default: ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg   <= in_data_byte;
            first_reg  <= in_first_byte;
            cancel_reg <= in_cancel;
        end
    end

    // Start of buffer, cancel and header/payload handling for one byte
    always_comb
    begin
        idle = (offset_reg == '0) && (outcome_reg == nce_pkg::VERDICT_CHECKING)
               && (hdr_pos_reg == '0) && (skip_reg == '0) && (open_levels_reg == '0);
        start   = first_reg || idle;
        blen32  = 32'(buffer_length_reg);
        bad_len = (blen32 < 32'(nce_pkg::HEADER_BYTES))
                  || (buffer_length_reg > size_limit_reg) || (blen32 > OFF_MAX);

        s_off     = start ? '0 : offset_reg;
        s_hp      = start ? '0 : hdr_pos_reg;
        s_sw      = start ? '0 : size_word_reg;
        s_skip    = start ? '0 : skip_reg;
        s_open    = start ? '0 : open_levels_reg;
        s_top     = start ? blen32[OFFSET_BITS-1:0] : top_end_reg;
        s_outcome = start ? (bad_len ? nce_pkg::VERDICT_REJECTED : nce_pkg::VERDICT_CHECKING)
                          : outcome_reg;

        off_inc   = s_off + OFFSET_BITS'(1);
        // size bytes arrive least significant first, so shift in from the top
        sw_shift  = (s_hp >= HDR_SIZE0) ? {byte_reg, s_sw[31:8]} : s_sw;
        payload32 = {1'b0, sw_shift[nce_pkg::NESTED_BIT-1:0]};
        room      = (s_top >= off_inc) ? (s_top - off_inc) : '0;
        new_end   = off_inc + payload32[OFFSET_BITS-1:0];

        st_off     = s_off;
        st_hp      = s_hp;
        st_sw      = s_sw;
        st_skip    = s_skip;
        st_open    = s_open;
        st_top     = s_top;
        st_outcome = s_outcome;
        st_push    = 1'b0;

        if (s_outcome == nce_pkg::VERDICT_CHECKING && cancel_reg)
        begin
            st_outcome = nce_pkg::VERDICT_CANCELLED;
        end
        else if (s_outcome == nce_pkg::VERDICT_CHECKING)
        begin
            st_off = off_inc;
            if (s_skip != '0)
            begin
                st_skip = s_skip - OFFSET_BITS'(1);
            end
            else if (s_hp != HDR_LAST)
            begin
                st_hp = s_hp + 3'd1;
                st_sw = sw_shift;
            end
            else
            begin
                // header complete
                st_hp = '0;
                st_sw = sw_shift;
                if (payload32 > 32'(room))
                begin
                    st_outcome = nce_pkg::VERDICT_REJECTED;
                end
                else if (sw_shift[nce_pkg::NESTED_BIT] && (payload32 != '0))
                begin
                    if (s_open >= OPEN_W'(MAX_OPEN))
                    begin
                        st_outcome = nce_pkg::VERDICT_REJECTED;
                    end
                    else
                    begin
                        st_open = s_open + OPEN_W'(1);
                        st_top  = new_end;
                        st_push = 1'b1;
                        st_sw   = '0;
                    end
                end
                else
                begin
                    st_skip = payload32[OFFSET_BITS-1:0];
                    st_sw   = '0;
                end
            end
        end
    end

    // Boundary check against the innermost open level
    assign at_end    = (offset_reg == top_end_reg);
    assign at_root   = (open_levels_reg == '0);
    assign gap       = top_end_reg - offset_reg;
    assign short_gap = (top_end_reg < offset_reg) || (32'(gap) < 32'(nce_pkg::HEADER_BYTES));

    // Next state selection per command
    always_comb
    begin
        offset_next      = offset_reg;
        hdr_pos_next     = hdr_pos_reg;
        size_word_next   = size_word_reg;
        skip_next        = skip_reg;
        open_levels_next = open_levels_reg;
        top_end_next     = top_end_reg;
        outcome_next     = outcome_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = st_top;
        mem_re           = 1'b0;
        mem_raddr        = open_levels_reg - OPEN_W'(1);

        if (cmd.step)
        begin
            offset_next      = st_off;
            hdr_pos_next     = st_hp;
            size_word_next   = st_sw;
            skip_next        = st_skip;
            open_levels_next = st_open;
            top_end_next     = st_top;
            outcome_next     = st_outcome;
            // root end goes to entry zero, a new level above the current one
            mem_we    = start || st_push;
            mem_waddr = st_push ? st_open : '0;
        end
        else if (cmd.check)
        begin
            if (at_end)
            begin
                if (at_root)
                begin
                    outcome_next = nce_pkg::VERDICT_ACCEPTED;
                end
                else
                begin
                    open_levels_next = open_levels_reg - OPEN_W'(1);
                    mem_re           = 1'b1;
                end
            end
            else if (short_gap)
            begin
                outcome_next = nce_pkg::VERDICT_REJECTED;
            end
        end
        else if (cmd.pop_load)
        begin
            top_end_next = mem_rdata;
        end
    end

    // Checker state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            hdr_pos_reg     <= '0;
            size_word_reg   <= '0;
            skip_reg        <= '0;
            open_levels_reg <= '0;
            outcome_reg     <= nce_pkg::VERDICT_CHECKING;
        end
        else
        begin
            offset_reg      <= offset_next;
            hdr_pos_reg     <= hdr_pos_next;
            size_word_reg   <= size_word_next;
            skip_reg        <= skip_next;
            open_levels_reg <= open_levels_next;
            outcome_reg     <= outcome_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_end_reg <= top_end_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_next)
        begin
            verdict_out_reg <= outcome_next;
            level_out_reg   <= 8'(open_levels_next);
        end
        else if (cmd.out_load_cur)
        begin
            verdict_out_reg <= outcome_reg;
            level_out_reg   <= 8'(open_levels_reg);
        end
    end

    // End-offset stack
    nce_ram #(
        .WIDTH (OFFSET_BITS),
        .DEPTH (STACK_ENTRIES)
    ) u_end_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign status.need_check = (st_outcome == nce_pkg::VERDICT_CHECKING)
                               && (st_skip == '0) && (st_hp == '0);
    assign status.at_end     = at_end;
    assign status.at_root    = at_root;

    assign out_verdict       = verdict_out_reg;
    assign out_nesting_level = level_out_reg;

    `NCE_ASSERT(a_open_bound, open_levels_reg <= OPEN_W'(MAX_OPEN), "open levels above stack limit")
    `NCE_ASSERT_NEXT(a_pop_one_level, cmd.check && at_end && !at_root, open_levels_reg == $past(open_levels_reg) - OPEN_W'(1), "closing a level did not drop depth by one")

endmodule

### hdl/nce_controller.sv
// Controller: sequences accept, byte step, boundary checks, stack reads and result hand-off.
`timescale 1ns / 1ps
`include "nested_chunk_envelope_checker_macros.svh"

module nce_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  nce_pkg::nce_status_t status,
    output nce_pkg::nce_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STEP  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_POP   = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       pop;
    logic       finish;
    logic       out_free;

    // Decode
    assign pop      = (state_reg == ST_CHECK) && status.at_end && !status.at_root;
    assign finish   = ((state_reg == ST_STEP) && !status.need_check)
                      || ((state_reg == ST_CHECK) && !pop);
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready          = (state_reg == ST_IDLE);
    assign cmd.capture       = (state_reg == ST_IDLE) && in_valid;
    assign cmd.step          = (state_reg == ST_STEP);
    assign cmd.check         = (state_reg == ST_CHECK);
    assign cmd.pop_load      = (state_reg == ST_POP);
    assign cmd.out_load_next = finish && out_free;
    assign cmd.out_load_cur  = (state_reg == ST_HOLD) && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (status.need_check)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_CHECK:
            begin
                if (pop)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_POP:
            begin
                state_next = ST_CHECK;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        priority if (cmd.out_load_next || cmd.out_load_cur)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `NCE_ASSERT_NEXT(a_accept_steps, in_valid && in_ready, state_reg == ST_STEP, "accepted item not stepped next cycle")
    `NCE_ASSERT(a_pop_after_check, state_reg == ST_POP |-> $past(state_reg) == ST_CHECK, "stack read without a boundary check")
    `NCE_ASSERT(a_result_after_finish, $rose(out_valid_reg) |-> ($past(state_reg) == ST_STEP || $past(state_reg) == ST_CHECK || $past(state_reg) == ST_HOLD), "result raised outside a finishing state")

endmodule

### hdl/nested_chunk_envelope_checker.sv
// Top level of the nested chunk envelope checker: controller, datapath and channel wiring.
//
//   channel     dir  handshake       payload
//   item_in     in   valid / ready   data_byte[7:0], first_byte, cancel
//   result_out  out  valid / ready   verdict[1:0], nesting_level[7:0]
//   wr_*        in   wr_en           wr_index[0], wr_data[23:0]
//
// A byte inside a header or payload passes through accept and step. A byte
// that ends a chunk passes through accept, step and a boundary compare, then one
// end-stack memory read and one more boundary compare per level closed at that offset.
// No clearing pass after reset: the stack is written before it is read.
// A finished result waits in the output register; the next byte is still
// accepted, and its result waits in the datapath state until the register frees.
`timescale 1ns / 1ps

module nested_chunk_envelope_checker #(
    parameter int STACK_ENTRIES = nce_pkg::STACK_ENTRIES_DEF,
    parameter int OFFSET_BITS   = nce_pkg::OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nce_in_if.sink                          item_in,
    nce_out_if.source                       result_out,
    input  logic                            wr_en,
    input  logic [nce_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [nce_pkg::REG_W-1:0]       wr_data
);

    nce_pkg::nce_cmd_t    cmd;
    nce_pkg::nce_status_t status;

    // Sequencer
    nce_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Checker datapath
    nce_datapath #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .in_data_byte      (item_in.data_byte),
        .in_first_byte     (item_in.first_byte),
        .in_cancel         (item_in.cancel),
        .cmd               (cmd),
        .status            (status),
        .out_verdict       (result_out.verdict),
        .out_nesting_level (result_out.nesting_level)
    );

endmodule
